@@ rtl/core/rafd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rafd_pkg
// constants and types for the running average frame difference core
// ----------------------------------------------------------------------------
package rafd_pkg;

    localparam int MAX_PIXELS = 131072;
    localparam int POS_W      = $clog2(MAX_PIXELS);
    localparam int FILL_W     = POS_W + 1;
    localparam int FRAME_W    = 18;
    localparam int CH_W       = 8;
    localparam int ACC_W      = 16;
    localparam int WEIGHT_W   = 17;
    localparam int CHANNELS   = 3;
    localparam int KEEP_W     = ACC_W + WEIGHT_W;
    localparam int NEW_W      = CH_W + WEIGHT_W;
    localparam int SUM_W      = KEEP_W + 1;

    localparam logic [WEIGHT_W-1:0] ONE_Q16            = WEIGHT_W'(65536);
    localparam logic [FRAME_W-1:0]  FRAME_PIXELS_RESET = FRAME_W'(76800);
    localparam logic [SUM_W-1:0]    ROUND_HALF         = SUM_W'(32768);
    localparam logic [CH_W-1:0]     DIFF_MAX           = CH_W'(255);

    typedef logic [CH_W-1:0]  pix_t;
    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        acc_t blue;
        acc_t green;
        acc_t red;
    } entry_t;

endpackage

@@ rtl/core/running_average_frame_difference_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_frame_difference_core
// running average background subtraction on an rgb pixel stream
//
// pixel channel (pixel_valid / pixel_ready) takes one rgb pixel and its
// weight per item, in raster order. result channel (result_valid /
// result_ready) returns the rounded absolute difference of each channel
// against the stored 8.8 average, and frame_end on the last pixel of a frame.
// the configuration write (cfg_wr_en / cfg_wr_data) sets the frame size and
// must only be used while the core is idle; the core does not enforce this.
// an accepted item passes through memory read, multiply, then add and write
// back into the output register.
// throughput is one item per cycle while the receiver does not stall; the
// average memory has one read and one write port. an item whose entry is
// still in the read-modify-write pipe waits, which happens only at frame
// sizes of one and two.
// reset sets the position to zero, the frame size to 76800 and the fill count
// to zero: entries at or above the fill count read as zero, so no clearing
// pass runs and items are taken from the first cycle after reset.
// when the receiver stalls, the output register holds its item and the pipe
// keeps filling its empty stages until it is full, then pixel_ready drops.
// ----------------------------------------------------------------------------
module running_average_frame_difference_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic [rafd_pkg::CH_W-1:0]           red_in,
    input  logic [rafd_pkg::CH_W-1:0]           green_in,
    input  logic [rafd_pkg::CH_W-1:0]           blue_in,
    input  logic [rafd_pkg::WEIGHT_W-1:0]       weight,

    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [rafd_pkg::CH_W-1:0]           red_diff,
    output logic [rafd_pkg::CH_W-1:0]           green_diff,
    output logic [rafd_pkg::CH_W-1:0]           blue_diff,
    output logic                                frame_end,

    input  logic                                cfg_wr_en,
    input  logic [rafd_pkg::FRAME_W-1:0]        cfg_wr_data
);

    localparam int CHN = rafd_pkg::CHANNELS;

    // average memory
    rafd_pkg::entry_t mem [rafd_pkg::MAX_PIXELS];
    rafd_pkg::entry_t rd_data_reg;
    rafd_pkg::entry_t wr_entry;

    // control
    rafd_pkg::pos_t                  pos_reg, pos_next;
    rafd_pkg::pos_t                  frame_last_reg, frame_last_next;
    logic [rafd_pkg::FILL_W-1:0]     fill_reg, fill_next;

    // stage 1
    logic                            s1_valid_reg;
    rafd_pkg::pos_t                  s1_pos_reg;
    rafd_pkg::pix_t                  s1_pix_reg [CHN];
    logic [rafd_pkg::WEIGHT_W-1:0]   s1_weight_reg;
    logic                            s1_last_reg;

    // stage 2
    logic                            s2_valid_reg;
    rafd_pkg::pos_t                  s2_pos_reg;
    rafd_pkg::pix_t                  s2_diff_reg [CHN];
    logic [rafd_pkg::KEEP_W-1:0]     s2_keep_reg [CHN];
    logic [rafd_pkg::NEW_W-1:0]      s2_new_reg [CHN];
    logic                            s2_last_reg;

    // output stage
    logic                            out_valid_reg;
    rafd_pkg::pix_t                  out_diff_reg [CHN];
    logic                            out_last_reg;

    logic                            out_load;
    logic                            s2_load;
    logic                            accept;
    logic                            hazard;
    logic                            pos_last;
    logic [rafd_pkg::WEIGHT_W-1:0]   weight_sat;
    logic [rafd_pkg::WEIGHT_W-1:0]   weight_inv;
    logic                            s1_written;
    rafd_pkg::acc_t                  s1_acc [CHN];
    rafd_pkg::pix_t                  s1_diff [CHN];
    logic [rafd_pkg::KEEP_W-1:0]     s1_keep [CHN];
    logic [rafd_pkg::NEW_W-1:0]      s1_new [CHN];
    rafd_pkg::acc_t                  s2_avg [CHN];
    rafd_pkg::pix_t                  pix_in [CHN];

    assign pix_in[0] = red_in;
    assign pix_in[1] = green_in;
    assign pix_in[2] = blue_in;

    // stage flow
    assign out_load = s2_valid_reg && (!out_valid_reg || result_ready);
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_load);

    // same entry still in the read-modify-write pipe
    assign hazard = (s1_valid_reg && (s1_pos_reg == pos_reg))
                 || (s2_valid_reg && (s2_pos_reg == pos_reg));

    assign pixel_ready = (!s1_valid_reg || s2_load) && !hazard;
    assign accept      = pixel_valid && pixel_ready;

    assign pos_last  = (pos_reg >= frame_last_reg);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = pos_last ? '0 : pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        frame_last_next = frame_last_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                frame_last_next = '0;
            end
            else if (cfg_wr_data > rafd_pkg::FRAME_W'(rafd_pkg::MAX_PIXELS))
            begin
                frame_last_next = rafd_pkg::POS_W'(rafd_pkg::MAX_PIXELS - 1);
            end
            else
            begin
                frame_last_next = rafd_pkg::POS_W'(cfg_wr_data - 1'b1);
            end
        end
    end

    // writes always extend or revisit the written prefix
    always_comb
    begin
        fill_next = fill_reg;
        if (out_load && ({1'b0, s2_pos_reg} == fill_reg))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign weight_sat = (weight > rafd_pkg::ONE_Q16) ? rafd_pkg::ONE_Q16 : weight;
    assign weight_inv = rafd_pkg::ONE_Q16 - s1_weight_reg;
    assign s1_written = ({1'b0, s1_pos_reg} < fill_reg);

    assign s1_acc[0] = s1_written ? rd_data_reg.red   : '0;
    assign s1_acc[1] = s1_written ? rd_data_reg.green : '0;
    assign s1_acc[2] = s1_written ? rd_data_reg.blue  : '0;

    always_comb
    begin
        logic [rafd_pkg::ACC_W-1:0] p;
        logic [rafd_pkg::ACC_W-1:0] d;
        logic [rafd_pkg::ACC_W:0]   r;
        for (int c = 0; c < CHN; c++)
        begin
            p = {s1_pix_reg[c], 8'd0};
            d = (s1_acc[c] > p) ? (s1_acc[c] - p) : (p - s1_acc[c]);
            r = (rafd_pkg::ACC_W+1)'(d) + (rafd_pkg::ACC_W+1)'(128);
            s1_diff[c] = r[rafd_pkg::ACC_W] ? rafd_pkg::DIFF_MAX : r[15:8];
            s1_keep[c] = rafd_pkg::KEEP_W'(s1_acc[c]) * rafd_pkg::KEEP_W'(weight_inv);
            s1_new[c]  = rafd_pkg::NEW_W'(s1_pix_reg[c]) * rafd_pkg::NEW_W'(s1_weight_reg);
        end
    end

    always_comb
    begin
        logic [rafd_pkg::SUM_W-1:0] t;
        for (int c = 0; c < CHN; c++)
        begin
            t = rafd_pkg::SUM_W'(s2_keep_reg[c])
              + rafd_pkg::SUM_W'({s2_new_reg[c], 8'd0})
              + rafd_pkg::ROUND_HALF;
            s2_avg[c] = t[31:16];
        end
    end

    assign wr_entry.red   = s2_avg[0];
    assign wr_entry.green = s2_avg[1];
    assign wr_entry.blue  = s2_avg[2];

    // memory ports
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[pos_reg];
        end
        if (out_load)
        begin
            mem[s2_pos_reg] <= wr_entry;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            frame_last_reg <= rafd_pkg::POS_W'(rafd_pkg::FRAME_PIXELS_RESET - 1'b1);
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            frame_last_reg <= frame_last_next;
            fill_reg       <= fill_next;
            if (accept || s2_load)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_load || out_load)
            begin
                s2_valid_reg <= s2_load;
            end
            if (out_load || result_ready)
            begin
                out_valid_reg <= out_load;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg    <= pos_reg;
            s1_weight_reg <= weight_sat;
            s1_last_reg   <= pos_last;
            for (int c = 0; c < CHN; c++)
            begin
                s1_pix_reg[c] <= pix_in[c];
            end
        end
        if (s2_load)
        begin
            s2_pos_reg  <= s1_pos_reg;
            s2_last_reg <= s1_last_reg;
            for (int c = 0; c < CHN; c++)
            begin
                s2_diff_reg[c] <= s1_diff[c];
                s2_keep_reg[c] <= s1_keep[c];
                s2_new_reg[c]  <= s1_new[c];
            end
        end
        if (out_load)
        begin
            out_last_reg <= s2_last_reg;
            for (int c = 0; c < CHN; c++)
            begin
                out_diff_reg[c] <= s2_diff_reg[c];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign red_diff     = out_diff_reg[0];
    assign green_diff   = out_diff_reg[1];
    assign blue_diff    = out_diff_reg[2];
    assign frame_end    = out_last_reg;

    // no two items in the pipe work on the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg |-> s1_pos_reg != s2_pos_reg)
        else $error("two items in flight on one entry");

    // fill count stays within the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= rafd_pkg::FILL_W'(rafd_pkg::MAX_PIXELS))
        else $error("fill count past memory depth");

    // write back never leaves a gap above the written prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> {1'b0, s2_pos_reg} <= fill_reg)
        else $error("write beyond fill count");

    // last pixel of a frame sends the counter back to the start
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos_last |=> pos_reg == '0)
        else $error("position did not wrap at frame end");

endmodule
